>>> rtl/core/pcpd_pkg.sv
// Shared types and constants for the polyline closest point distance unit.
package pcpd_pkg;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic               new_polyline;
    } in_item_t;

    typedef struct packed {
        logic               found;
        logic [16:0]        distance;
        logic signed [15:0] nearest_x;
        logic signed [15:0] nearest_y;
        logic               overflowed;
    } out_item_t;

endpackage

>>> rtl/core/pcpd_if.sv
// Valid/ready channel interfaces for input and result transactions.
interface pcpd_in_if;
    import pcpd_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pcpd_out_if;
    import pcpd_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/pcpd_front.sv
// Front end: accepts transactions and queues the actions that do work.
module pcpd_front (
    input  logic             clk,
    input  logic             rst_n,
    pcpd_in_if.sink          in_ch,
    output pcpd_pkg::in_item_t q_data,
    output logic             q_valid,
    input  logic             q_pop
);
    import pcpd_pkg::*;

    localparam int Depth = 4;

    in_item_t   fifo_reg [Depth];
    logic [1:0] wr_reg, rd_reg, wr_next, rd_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       push;

    assign in_ch.ready = (cnt_reg != 3'(Depth));
    // drop unknown actions at the door
    assign push = in_ch.valid && in_ch.ready && (in_ch.data.action != ACT_NONE);
    assign q_valid = (cnt_reg != 3'd0);
    assign q_data = fifo_reg[rd_reg];

    always_comb
    begin
        wr_next = push ? wr_reg + 2'd1 : wr_reg;
        rd_next = q_pop ? rd_reg + 2'd1 : rd_reg;
        cnt_next = cnt_reg + {2'd0, push} - {2'd0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_reg] <= in_ch.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

>>> rtl/core/pcpd_div.sv
// Sequential restoring divider, one quotient bit per cycle.
module pcpd_div #(
    parameter int W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  q_reg, d_reg;
    logic [W:0]    r_reg;
    logic [CW-1:0] n_reg;
    logic          busy_reg;
    logic [W:0]    shr;

    assign shr = {r_reg[W-1:0], q_reg[W-1]};
    assign quotient = q_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            d_reg <= divisor;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (shr >= {1'b0, d_reg})
            begin
                r_reg <= shr - {1'b0, d_reg};
                q_reg <= {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= shr;
                q_reg <= {q_reg[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            n_reg <= '0;
            done <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                n_reg <= CW'(W);
            end
            else if (busy_reg)
            begin
                n_reg <= n_reg - 1'b1;
                if (n_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
            end
        end
    end
endmodule

>>> rtl/core/pcpd_back.sv
// Back end: vertex store, segment walk, projection and square root.
module pcpd_back #(
    parameter int MAX_VERTICES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pcpd_pkg::in_item_t q_data,
    input  logic               q_valid,
    output logic               q_pop,
    pcpd_out_if.source         out_ch
);
    import pcpd_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int DW = 52;

    typedef enum logic [3:0] {
        S_IDLE, S_RDA, S_RDB, S_MUL, S_SUM, S_NUM, S_CLAMP, S_DIVX, S_WAITX, S_DIVY,
        S_WAITY, S_ERR, S_SQ, S_CMP, S_SQRT, S_OUT
    } state_t;

    state_t state_reg;
    logic [32:0] mem [MAX_VERTICES];
    logic [32:0] rd_reg;
    logic [CW-1:0] cnt_reg, j_reg;
    logic dropped_reg;
    logic signed [17:0] qx_reg, qy_reg, ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [17:0] ux_reg, uy_reg, wx_reg, wy_reg, nx_reg, ny_reg;
    logic signed [35:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [37:0] num_reg;
    logic [36:0] den_reg;
    logic [35:0] sq_reg, best_sq_reg;
    logic [17:0] ex_reg, ey_reg;
    logic found_reg;
    logic signed [15:0] best_x_reg, best_y_reg;
    logic div_start, div_done;
    logic [DW-1:0] div_a, div_b, div_q;
    logic [17:0] mag;
    logic [55:0] mx;
    // square root
    logic [35:0] rem_reg, root_reg, bit_reg;
    logic [AW-1:0] rd_addr;
    logic      load_res;
    out_item_t res_reg;
    logic      ov_reg;

    assign out_ch.valid = ov_reg;
    assign out_ch.data = res_reg;
    assign q_pop = (state_reg == S_IDLE) && q_valid && !ov_reg;
    assign load_res = (state_reg == S_OUT) && (!ov_reg || out_ch.ready);

    pcpd_div #(.W(DW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(div_a), .divisor(div_b), .done(div_done), .quotient(div_q)
    );

    // round(|d|*num/den) = (2*|d|*num + den) / (2*den); num < den < 2^34 here
    always_comb
    begin
        if (state_reg == S_DIVX)
            mag = (ux_reg < 0) ? -ux_reg : ux_reg;
        else
            mag = (uy_reg < 0) ? -uy_reg : uy_reg;
        mx = 56'(mag) * 56'(num_reg[33:0]);
        div_start = (state_reg == S_DIVX) || (state_reg == S_DIVY);
        div_a = DW'({mx, 1'b0} + 57'(den_reg));
        div_b = DW'({den_reg, 1'b0});
    end

    assign rd_addr = (state_reg == S_RDA) ? AW'(j_reg) : AW'(j_reg + 1'b1);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_pop && q_data.action == ACT_APPEND
            && cnt_reg < CW'(MAX_VERTICES))
        begin
            mem[AW'(cnt_reg)] <= {q_data.px, q_data.py, q_data.new_polyline};
        end
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            dropped_reg <= 1'b0;
            ov_reg <= 1'b0;
            j_reg <= '0;
            found_reg <= 1'b0;
            qx_reg <= '0;
            qy_reg <= '0;
            ax_reg <= '0;
            ay_reg <= '0;
            bx_reg <= '0;
            by_reg <= '0;
            ux_reg <= '0;
            uy_reg <= '0;
            wx_reg <= '0;
            wy_reg <= '0;
            nx_reg <= '0;
            ny_reg <= '0;
            m1_reg <= '0;
            m2_reg <= '0;
            m3_reg <= '0;
            m4_reg <= '0;
            num_reg <= '0;
            den_reg <= '0;
            sq_reg <= '0;
            best_sq_reg <= '0;
            ex_reg <= '0;
            ey_reg <= '0;
            best_x_reg <= '0;
            best_y_reg <= '0;
            rem_reg <= '0;
            root_reg <= '0;
            bit_reg <= '0;
            res_reg <= '0;
        end
        else
        begin
            if (load_res)
                ov_reg <= 1'b1;
            else if (out_ch.ready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        unique case (q_data.action)
                            ACT_CLEAR:
                            begin
                                cnt_reg <= '0;
                                dropped_reg <= 1'b0;
                            end
                            ACT_APPEND:
                            begin
                                if (cnt_reg < CW'(MAX_VERTICES))
                                    cnt_reg <= cnt_reg + 1'b1;
                                else
                                    dropped_reg <= 1'b1;
                            end
                            ACT_QUERY:
                            begin
                                qx_reg <= 18'(q_data.px);
                                qy_reg <= 18'(q_data.py);
                                j_reg <= '0;
                                found_reg <= 1'b0;
                                best_sq_reg <= '0;
                                best_x_reg <= '0;
                                best_y_reg <= '0;
                                state_reg <= S_RDA;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_RDA:
                begin
                    if (j_reg + 1'b1 >= cnt_reg)
                    begin
                        rem_reg <= best_sq_reg;
                        root_reg <= '0;
                        bit_reg <= 36'd1 << 34;
                        state_reg <= S_SQRT;
                    end
                    else
                        state_reg <= S_RDB;
                end
                S_RDB:
                begin
                    ax_reg <= 18'($signed(rd_reg[32:17]));
                    ay_reg <= 18'($signed(rd_reg[16:1]));
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    // drop the segment when its end vertex starts a new polyline
                    if (rd_reg[0])
                    begin
                        j_reg <= j_reg + 1'b1;
                        state_reg <= S_RDA;
                    end
                    else
                    begin
                        bx_reg <= 18'($signed(rd_reg[32:17]));
                        by_reg <= 18'($signed(rd_reg[16:1]));
                        ux_reg <= 18'($signed(rd_reg[32:17])) - ax_reg;
                        uy_reg <= 18'($signed(rd_reg[16:1])) - ay_reg;
                        wx_reg <= qx_reg - ax_reg;
                        wy_reg <= qy_reg - ay_reg;
                        state_reg <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    m1_reg <= wx_reg * ux_reg;
                    m2_reg <= wy_reg * uy_reg;
                    m3_reg <= ux_reg * ux_reg;
                    m4_reg <= uy_reg * uy_reg;
                    state_reg <= S_NUM;
                end
                S_NUM:
                begin
                    num_reg <= 38'(m1_reg) + 38'(m2_reg);
                    den_reg <= 37'(m3_reg) + 37'(m4_reg);
                    state_reg <= S_CLAMP;
                end
                S_CLAMP:
                begin
                    if (den_reg == '0 || num_reg <= 0)
                    begin
                        nx_reg <= ax_reg;
                        ny_reg <= ay_reg;
                        state_reg <= S_ERR;
                    end
                    else if (num_reg >= $signed({1'b0, den_reg}))
                    begin
                        nx_reg <= bx_reg;
                        ny_reg <= by_reg;
                        state_reg <= S_ERR;
                    end
                    else
                        state_reg <= S_DIVX;
                end
                S_DIVX:
                begin
                    state_reg <= S_WAITX;
                end
                S_WAITX:
                begin
                    if (div_done)
                    begin
                        nx_reg <= (ux_reg < 0) ? ax_reg - 18'(div_q) : ax_reg + 18'(div_q);
                        state_reg <= S_DIVY;
                    end
                end
                S_DIVY:
                begin
                    state_reg <= S_WAITY;
                end
                S_WAITY:
                begin
                    if (div_done)
                    begin
                        ny_reg <= (uy_reg < 0) ? ay_reg - 18'(div_q) : ay_reg + 18'(div_q);
                        state_reg <= S_ERR;
                    end
                end
                S_ERR:
                begin
                    ex_reg <= 18'(qx_reg > nx_reg ? qx_reg - nx_reg : nx_reg - qx_reg);
                    ey_reg <= 18'(qy_reg > ny_reg ? qy_reg - ny_reg : ny_reg - qy_reg);
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    sq_reg <= 36'(ex_reg) * 36'(ex_reg) + 36'(ey_reg) * 36'(ey_reg);
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (!found_reg || sq_reg < best_sq_reg)
                    begin
                        found_reg <= 1'b1;
                        best_sq_reg <= sq_reg;
                        best_x_reg <= 16'(nx_reg);
                        best_y_reg <= 16'(ny_reg);
                    end
                    j_reg <= j_reg + 1'b1;
                    state_reg <= S_RDA;
                end
                S_SQRT:
                begin
                    if (bit_reg == '0)
                    begin
                        state_reg <= S_OUT;
                    end
                    else if (rem_reg >= root_reg + bit_reg)
                    begin
                        rem_reg <= rem_reg - root_reg - bit_reg;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end
                    else
                        root_reg <= root_reg >> 1;
                    if (bit_reg != '0)
                        bit_reg <= bit_reg >> 2;
                end
                S_OUT:
                begin
                    if (load_res)
                    begin
                        res_reg.found <= found_reg;
                        res_reg.distance <= found_reg ?
                            17'((rem_reg > root_reg) ? root_reg + 36'd1 : root_reg) : '0;
                        res_reg.nearest_x <= best_x_reg;
                        res_reg.nearest_y <= best_y_reg;
                        res_reg.overflowed <= dropped_reg;
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end
endmodule

>>> rtl/core/polyline_closest_point_distance_unit.sv
// Top level of the polyline closest point distance unit.
// Transactions enter a four-deep queue and unknown actions are dropped at the door; clear and
// append are carried out when the idle back end pops them from the head of the queue. A query
// walks the stored segments: a segment is split off when its end vertex starts a new polyline,
// a projection that clamps to an end point takes that end point, and one that lands inside the
// segment needs two 52-bit serial divides, which set the pace. After the walk a serial square
// root gives the distance and the result is output. A finished result holds the back end until
// it is taken.
module polyline_closest_point_distance_unit #(
    parameter int MAX_VERTICES = 64
) (
    input logic        clk,
    input logic        rst_n,
    pcpd_in_if.sink    in_ch,
    pcpd_out_if.source out_ch
);
    import pcpd_pkg::*;

    in_item_t q_data;
    logic     q_valid, q_pop;

    pcpd_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
    );

    pcpd_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
        .clk(clk), .rst_n(rst_n), .q_data(q_data), .q_valid(q_valid),
        .q_pop(q_pop), .out_ch(out_ch)
    );
endmodule
